>>> hw/rtl/seeded_region_grow_core_assert.svh
// Assertion macros shared by the region grow RTL.
`ifndef SEEDED_REGION_GROW_CORE_ASSERT_SVH
`define SEEDED_REGION_GROW_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define SRG_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
`define SRG_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("assertion failed");
`else
`define SRG_ASSERT(label, clk, rst_n, prop)
`define SRG_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

>>> hw/rtl/srg_pkg.sv
package srg_pkg;
	localparam int MAX_WIDTH_DEF = 256;
	localparam int MAX_HEIGHT_DEF = 256;
	localparam int PIXEL_W = 8;
	localparam int COUNT_W = 17;
	localparam int SUM_W = 24;
	localparam int CFG_W = 9;

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_GROW = 2'd1,
		OP_READ = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		REG_WIDTH = 3'd0,
		REG_HEIGHT = 3'd1,
		REG_SEED_COL = 3'd2,
		REG_SEED_ROW = 3'd3,
		REG_THRESHOLD = 3'd4
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_SEED,
		ST_SEED_WAIT,
		ST_POP,
		ST_POP_WAIT,
		ST_NBR,
		ST_NBR_WAIT,
		ST_NBR_TEST,
		ST_DIV,
		ST_READ_WAIT,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} div_ctrl_t;
endpackage

>>> hw/rtl/srg_ram.sv
module srg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> hw/rtl/srg_div.sv
module srg_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [srg_pkg::SUM_W-1:0]   dividend,
	input  logic [srg_pkg::COUNT_W-1:0] divisor,
	output srg_pkg::div_ctrl_t          ctrl,
	output logic [srg_pkg::PIXEL_W-1:0] quotient
);
	localparam int SW = srg_pkg::SUM_W;
	localparam int CW = srg_pkg::COUNT_W;

	logic [SW-1:0] quo_q;
	logic [CW:0]   rem_q;
	logic [CW-1:0] dvs_q;
	logic [$clog2(SW+1)-1:0] cnt_q;
	logic busy_q, done_q;
	logic [CW:0] shifted;
	logic [CW:0] diff;

	assign shifted = {rem_q[CW-1:0], quo_q[SW-1]};
	assign diff = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= ($clog2(SW+1))'(SW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[CW]) begin
				rem_q <= diff;
				quo_q <= {quo_q[SW-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[SW-2:0], 1'b0};
			end
		end
	end

	assign ctrl = '{start: start, busy: busy_q, done: done_q};
	assign quotient = quo_q[srg_pkg::PIXEL_W-1:0];
endmodule

>>> hw/rtl/seeded_region_grow_core.sv
// A load writes its pixel and leaves the core idle. A mask read passes through the READ_WAIT
// and OUT states before its result is offered, and the next input is taken in the cycle
// after the result transfer. A grow first clears all MAX_WIDTH*MAX_HEIGHT mask entries, then
// walks the queue of region pixels, testing the eight neighbours of each and updating the
// mean with the single 24-step divider; a waiting result holds off the next input.
// Reset is asynchronous and active low; the mask reads as zero until the first grow.
`include "seeded_region_grow_core_assert.svh"
module seeded_region_grow_core #(
	parameter int MAX_WIDTH = srg_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = srg_pkg::MAX_HEIGHT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [8:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// operation[1:0], pixel_index[17:2], pixel_value[25:18], zeros
	input  logic [31:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// region_count[16:0], seed_error[17], in_region[18], zeros
	output logic [23:0] m_tdata
);
	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);
	localparam int AW = XW + YW;
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int DW = XW + 1;
	localparam int HW = YW + 1;
	localparam int PW = srg_pkg::PIXEL_W;
	localparam int CW = srg_pkg::COUNT_W;
	localparam int SW = srg_pkg::SUM_W;
	localparam int QCW = AW + 1;

	logic [8:0] width_q, height_q, thr_q;
	logic [7:0] seed_col_q, seed_row_q;
	logic [DW-1:0] w_eff;
	logic [HW-1:0] h_eff;

	always_comb begin
		if (width_q == '0) w_eff = DW'(1);
		else if (32'(width_q) > MAX_WIDTH) w_eff = DW'(MAX_WIDTH);
		else w_eff = DW'(width_q);
		if (height_q == '0) h_eff = HW'(1);
		else if (32'(height_q) > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
		else h_eff = HW'(height_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 9'd256;
			height_q <= 9'd256;
			seed_col_q <= '0;
			seed_row_q <= '0;
			thr_q <= 9'd7;
		end else if (cfg_we) begin
			case (cfg_index)
				srg_pkg::REG_WIDTH: width_q <= cfg_data;
				srg_pkg::REG_HEIGHT: height_q <= cfg_data;
				srg_pkg::REG_SEED_COL: seed_col_q <= cfg_data[7:0];
				srg_pkg::REG_SEED_ROW: seed_row_q <= cfg_data[7:0];
				srg_pkg::REG_THRESHOLD: thr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [1:0] in_op;
	logic [15:0] in_idx;
	logic [7:0] in_val;
	assign in_op = s_tdata[1:0];
	assign in_idx = s_tdata[17:2];
	assign in_val = s_tdata[25:18];

	srg_pkg::state_t state_q, state_d;
	logic [QCW-1:0] clr_q, head_q, total_q;
	logic [SW-1:0] sum_q;
	logic [PW-1:0] mean_q;
	logic [XW-1:0] cx_q;
	logic [YW-1:0] cy_q;
	logic [2:0] k_q;
	logic [XW-1:0] nx_q;
	logic [YW-1:0] ny_q;
	logic [AW-1:0] na_q;
	logic [CW-1:0] res_cnt_q;
	logic res_err_q, res_in_q, out_v_q;
	logic grown_q;

	logic px_we, mk_we, q_we, mk_wd;
	logic [AW-1:0] px_wa, px_ra, mk_wa, mk_ra, q_wa, q_ra;
	logic [AW-1:0] q_wd;
	logic [PW-1:0] px_rd;
	logic mk_rd;
	logic [AW-1:0] q_rd;

	srg_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_px (
		.clk(clk), .we(px_we), .waddr(px_wa), .wdata(in_val),
		.raddr(px_ra), .rdata(px_rd));
	srg_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_mk (
		.clk(clk), .we(mk_we), .waddr(mk_wa), .wdata(mk_wd),
		.raddr(mk_ra), .rdata(mk_rd));
	srg_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_q (
		.clk(clk), .we(q_we), .waddr(q_wa), .wdata(q_wd),
		.raddr(q_ra), .rdata(q_rd));

	logic div_start_q;
	srg_pkg::div_ctrl_t div_ctrl;
	logic [PW-1:0] div_quo;
	srg_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start_q),
		.dividend(sum_q), .divisor(CW'(total_q)),
		.ctrl(div_ctrl), .quotient(div_quo));

	logic in_fire;
	logic idx_ok;
	logic [AW-1:0] seed_addr;
	logic [XW:0] cand_x;
	logic [YW:0] cand_y;
	logic cand_in;
	logic [PW:0] diff;
	logic join_ok;
	logic signed [1:0] dx, dy;

	assign s_tready = (state_q == srg_pkg::ST_IDLE) && !out_v_q;
	assign in_fire = s_tvalid && s_tready;
	assign idx_ok = (32'(in_idx) < 32'(DEPTH));
	assign seed_addr = AW'(32'(seed_row_q) * 32'(w_eff) + 32'(seed_col_q));

	always_comb begin
		case (k_q)
			3'd0: begin dx = -2'sd1; dy = -2'sd1; end
			3'd1: begin dx = -2'sd1; dy = 2'sd0; end
			3'd2: begin dx = -2'sd1; dy = 2'sd1; end
			3'd3: begin dx = 2'sd1; dy = -2'sd1; end
			3'd4: begin dx = 2'sd1; dy = 2'sd0; end
			3'd5: begin dx = 2'sd1; dy = 2'sd1; end
			3'd6: begin dx = 2'sd0; dy = -2'sd1; end
			default: begin dx = 2'sd0; dy = 2'sd1; end
		endcase
		cand_x = {1'b0, cx_q} + {{(XW-1){dx[1]}}, dx};
		cand_y = {1'b0, cy_q} + {{(YW-1){dy[1]}}, dy};
		cand_in = !(dx == -2'sd1 && cx_q == '0) && !(dy == -2'sd1 && cy_q == '0)
			&& (32'(cand_x) < 32'(w_eff)) && (32'(cand_y) < 32'(h_eff));
		diff = (px_rd > mean_q) ? {1'b0, px_rd - mean_q} : {1'b0, mean_q - px_rd};
		join_ok = (9'(diff) < thr_q) && !mk_rd && (32'(total_q) < 32'(DEPTH));
	end

	always_comb begin
		state_d = state_q;
		px_we = 1'b0;
		mk_we = 1'b0;
		q_we = 1'b0;
		mk_wd = 1'b0;
		px_wa = in_idx[AW-1:0];
		px_ra = na_q;
		mk_wa = na_q;
		mk_ra = na_q;
		q_wa = total_q[AW-1:0];
		q_ra = head_q[AW-1:0];
		q_wd = {ny_q, nx_q};
		case (state_q)
			srg_pkg::ST_IDLE: begin
				mk_ra = in_idx[AW-1:0];
				if (in_fire) begin
					case (in_op)
						srg_pkg::OP_LOAD: px_we = idx_ok;
						srg_pkg::OP_GROW: state_d = srg_pkg::ST_CLEAR;
						srg_pkg::OP_READ: state_d = srg_pkg::ST_READ_WAIT;
						default: ;
					endcase
				end
			end
			srg_pkg::ST_READ_WAIT: state_d = srg_pkg::ST_OUT;
			srg_pkg::ST_CLEAR: begin
				mk_we = 1'b1;
				mk_wa = clr_q[AW-1:0];
				if (clr_q == QCW'(DEPTH - 1)) begin
					state_d = srg_pkg::ST_SEED;
				end
			end
			srg_pkg::ST_SEED: begin
				if (32'(seed_col_q) >= 32'(w_eff) || 32'(seed_row_q) >= 32'(h_eff)) begin
					state_d = srg_pkg::ST_OUT;
				end else begin
					px_ra = seed_addr;
					mk_we = 1'b1;
					mk_wa = seed_addr;
					mk_wd = 1'b1;
					q_we = 1'b1;
					q_wa = '0;
					q_wd = {YW'(seed_row_q), XW'(seed_col_q)};
					state_d = srg_pkg::ST_SEED_WAIT;
				end
			end
			srg_pkg::ST_SEED_WAIT: state_d = srg_pkg::ST_POP;
			srg_pkg::ST_POP: begin
				if (head_q < total_q) state_d = srg_pkg::ST_POP_WAIT;
				else state_d = srg_pkg::ST_OUT;
			end
			srg_pkg::ST_POP_WAIT: state_d = srg_pkg::ST_NBR;
			srg_pkg::ST_NBR: begin
				if (cand_in) state_d = srg_pkg::ST_NBR_WAIT;
				else if (k_q == 3'd7) state_d = srg_pkg::ST_DIV;
			end
			srg_pkg::ST_NBR_WAIT: state_d = srg_pkg::ST_NBR_TEST;
			srg_pkg::ST_NBR_TEST: begin
				if (join_ok) begin
					mk_we = 1'b1;
					mk_wd = 1'b1;
					q_we = 1'b1;
				end
				if (k_q == 3'd7) state_d = srg_pkg::ST_DIV;
				else state_d = srg_pkg::ST_NBR;
			end
			srg_pkg::ST_DIV: if (div_ctrl.done) state_d = srg_pkg::ST_POP;
			srg_pkg::ST_OUT: state_d = srg_pkg::ST_IDLE;
			default: state_d = srg_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srg_pkg::ST_IDLE;
			out_v_q <= 1'b0;
			clr_q <= '0;
			head_q <= '0;
			total_q <= '0;
			sum_q <= '0;
			mean_q <= '0;
			k_q <= '0;
			cx_q <= '0;
			cy_q <= '0;
			nx_q <= '0;
			ny_q <= '0;
			na_q <= '0;
			res_cnt_q <= '0;
			res_err_q <= 1'b0;
			res_in_q <= 1'b0;
			div_start_q <= 1'b0;
			grown_q <= 1'b0;
		end else begin
			state_q <= state_d;
			div_start_q <= (state_d == srg_pkg::ST_DIV) && (state_q != srg_pkg::ST_DIV);
			if (state_q == srg_pkg::ST_OUT) out_v_q <= 1'b1;
			else if (out_v_q && m_tready) out_v_q <= 1'b0;
			case (state_q)
				srg_pkg::ST_IDLE: begin
					clr_q <= '0;
					if (in_fire) res_in_q <= idx_ok;
				end
				srg_pkg::ST_READ_WAIT: begin
					res_in_q <= mk_rd && res_in_q && grown_q;
					res_cnt_q <= '0;
					res_err_q <= 1'b0;
				end
				srg_pkg::ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					grown_q <= 1'b1;
				end
				srg_pkg::ST_SEED: begin
					res_in_q <= 1'b0;
					head_q <= '0;
					if (state_d == srg_pkg::ST_OUT) begin
						res_err_q <= 1'b1;
						res_cnt_q <= '0;
						total_q <= '0;
						sum_q <= '0;
						mean_q <= '0;
					end else begin
						res_err_q <= 1'b0;
						total_q <= QCW'(1);
					end
				end
				srg_pkg::ST_SEED_WAIT: begin
					sum_q <= SW'(px_rd);
					mean_q <= px_rd;
				end
				srg_pkg::ST_POP: begin
					if (state_d == srg_pkg::ST_OUT) res_cnt_q <= CW'(total_q);
				end
				srg_pkg::ST_POP_WAIT: begin
					cx_q <= q_rd[XW-1:0];
					cy_q <= q_rd[AW-1:XW];
					k_q <= '0;
				end
				srg_pkg::ST_NBR: begin
					nx_q <= cand_x[XW-1:0];
					ny_q <= cand_y[YW-1:0];
					na_q <= AW'(32'(cand_y) * 32'(w_eff) + 32'(cand_x));
					if (!cand_in) k_q <= k_q + 1'b1;
				end
				srg_pkg::ST_NBR_TEST: begin
					k_q <= k_q + 1'b1;
					if (join_ok) begin
						total_q <= total_q + 1'b1;
						sum_q <= sum_q + SW'(px_rd);
					end
				end
				srg_pkg::ST_DIV: begin
					if (div_ctrl.done) begin
						mean_q <= div_quo;
						head_q <= head_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata = {5'd0, res_in_q, res_err_q, res_cnt_q};

	`SRG_ASSERT(a_no_accept_busy, clk, arst_n, !(in_fire && state_q != srg_pkg::ST_IDLE))
	`SRG_ASSERT_NEXT(a_out_follows, clk, arst_n, state_q == srg_pkg::ST_OUT, m_tvalid)
	`SRG_ASSERT(a_head_le_total, clk, arst_n, head_q <= total_q || state_q == srg_pkg::ST_CLEAR || state_q == srg_pkg::ST_IDLE)
endmodule
